/* rtl/hmhp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP message header parser package
// Beat types, part and status codes, parser phases and byte class helpers.
// ----------------------------------------------------------------------------
package hmhp_pkg;

  localparam int MAX_HEADERS = 64;
  localparam int HDR_W       = $clog2(MAX_HEADERS + 1);
  localparam int KEY_LEN     = 14;
  localparam int POS_W       = $clog2(KEY_LEN + 1);

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_CTL   = 8'h1f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] PART_DELIM   = 4'd0;
  localparam logic [3:0] PART_METHOD  = 4'd1;
  localparam logic [3:0] PART_PATH    = 4'd2;
  localparam logic [3:0] PART_QUERY   = 4'd3;
  localparam logic [3:0] PART_VERSION = 4'd4;
  localparam logic [3:0] PART_CODE    = 4'd5;
  localparam logic [3:0] PART_REASON  = 4'd6;
  localparam logic [3:0] PART_NAME    = 4'd7;
  localparam logic [3:0] PART_VALUE   = 4'd8;
  localparam logic [3:0] PART_CONTENT = 4'd9;

  localparam logic [1:0] STAT_PENDING  = 2'd0;
  localparam logic [1:0] STAT_COMPLETE = 2'd1;
  localparam logic [1:0] STAT_FAILED   = 2'd2;

  localparam logic MODE_REQUEST = 1'b0;

  typedef enum logic [10:0] {
    PH_START       = 11'b000_0000_0001,
    PH_PATH        = 11'b000_0000_0010,
    PH_VERSION     = 11'b000_0000_0100,
    PH_CODE        = 11'b000_0000_1000,
    PH_REASON      = 11'b000_0001_0000,
    PH_NAME        = 11'b000_0010_0000,
    PH_COLON_SPACE = 11'b000_0100_0000,
    PH_VALUE       = 11'b000_1000_0000,
    PH_CONTENT     = 11'b001_0000_0000,
    PH_DONE        = 11'b010_0000_0000,
    PH_FAIL        = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       message_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  part;
    logic [5:0]  header_index;
    logic [1:0]  parse_status;
    logic [31:0] content_length;
  } out_beat_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= CH_CTL) || (b == CH_DEL);
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    case (b) inside
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_sep(b);
  endfunction

  function automatic logic [7:0] key_char(input logic [POS_W-1:0] pos);
    case (pos)
      POS_W'(0):  return "C";
      POS_W'(1):  return "o";
      POS_W'(2):  return "n";
      POS_W'(3):  return "t";
      POS_W'(4):  return "e";
      POS_W'(5):  return "n";
      POS_W'(6):  return "t";
      POS_W'(7):  return "-";
      POS_W'(8):  return "L";
      POS_W'(9):  return "e";
      POS_W'(10): return "n";
      POS_W'(11): return "g";
      POS_W'(12): return "t";
      POS_W'(13): return "h";
      default:    return 8'h00;
    endcase
  endfunction

endpackage

/* rtl/http_message_header_parser.sv */
// ----------------------------------------------------------------------------
// HTTP message header parser
// Tags each byte of an HTTP/1.x request or response with its message part,
// checks its syntax, takes the Content-Length value and counts content.
// ----------------------------------------------------------------------------
//  channel  signals                     direction  beat
//  in       in_valid in_stall in_data   in         one byte and start flag
//  out      out_valid out_stall out_data out       tagged byte and status
//  cfg      cfg_valid cfg_ready cfg_data in        parse mode bit
//
//  One byte per cycle when not stalled; input register, then result register.
//  The parser state sits between the input register and the result register,
//  so the combinational next-phase logic sets the rate.
//  Reset clears the parser state and selects request parsing.
//  A stalled result holds; the input register still takes one more beat.
// ----------------------------------------------------------------------------
module http_message_header_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hmhp_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hmhp_pkg::out_beat_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import hmhp_pkg::*;

  logic             parse_mode;
  logic             hold_valid;
  in_beat_t         hold;
  logic             advance;

  phase_t           phase, phase_next;
  logic             awaiting_lf, awaiting_lf_next;
  logic             in_query, in_query_next;
  logic [POS_W-1:0] match_pos, match_pos_next;
  logic             mismatch, mismatch_next;
  logic [31:0]      accum, accum_next;
  logic             digits_ended, digits_ended_next;
  logic [31:0]      length, length_next;
  logic [31:0]      count, count_next;
  logic [HDR_W-1:0] headers, headers_next;
  logic [3:0]       part_next;

  phase_t           cur_phase;
  logic             cur_lf, cur_query, cur_mis, cur_ended;
  logic [POS_W-1:0] cur_pos;
  logic [31:0]      cur_accum, cur_length, cur_count;
  logic [HDR_W-1:0] cur_headers;
  logic [35:0]      accum_ext, accum_sum;
  logic [7:0]       b;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= MODE_REQUEST;
    end else if (cfg_valid) begin
      parse_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
  end

  always_comb begin
    b           = hold.in_byte;
    cur_phase   = hold.message_start ? PH_START : phase;
    cur_lf      = hold.message_start ? 1'b0 : awaiting_lf;
    cur_query   = hold.message_start ? 1'b0 : in_query;
    cur_pos     = hold.message_start ? '0 : match_pos;
    cur_mis     = hold.message_start ? 1'b0 : mismatch;
    cur_accum   = hold.message_start ? '0 : accum;
    cur_ended   = hold.message_start ? 1'b0 : digits_ended;
    cur_length  = hold.message_start ? '0 : length;
    cur_count   = hold.message_start ? '0 : count;
    cur_headers = hold.message_start ? '0 : headers;

    accum_ext = {4'd0, cur_accum};
    accum_sum = (accum_ext << 3) + (accum_ext << 1) + 36'(b[3:0]);

    phase_next        = cur_phase;
    awaiting_lf_next  = cur_lf;
    in_query_next     = cur_query;
    match_pos_next    = cur_pos;
    mismatch_next     = cur_mis;
    accum_next        = cur_accum;
    digits_ended_next = cur_ended;
    length_next       = cur_length;
    count_next        = cur_count;
    headers_next      = cur_headers;
    part_next         = PART_DELIM;

    if (cur_phase == PH_DONE || cur_phase == PH_FAIL) begin
      phase_next = cur_phase;
    end else if (cur_lf) begin
      awaiting_lf_next = 1'b0;
      if (b != CH_LF) begin
        phase_next = PH_FAIL;
      end else if (cur_phase == PH_VERSION || cur_phase == PH_REASON) begin
        match_pos_next = '0;
        mismatch_next  = 1'b0;
        phase_next     = PH_NAME;
      end else if (cur_phase == PH_VALUE) begin
        if (!cur_mis && cur_pos == POS_W'(KEY_LEN)) begin
          length_next = cur_accum;
        end
        if (cur_headers < HDR_W'(MAX_HEADERS)) begin
          headers_next = cur_headers + HDR_W'(1);
        end
        match_pos_next = '0;
        mismatch_next  = 1'b0;
        phase_next     = PH_NAME;
      end else if (cur_phase == PH_NAME) begin
        phase_next = (cur_length != '0) ? PH_CONTENT : PH_DONE;
      end else begin
        phase_next = PH_FAIL;
      end
    end else begin
      case (cur_phase)
        PH_START: begin
          if (parse_mode == MODE_REQUEST) begin
            if (b == CH_SPACE) phase_next = PH_PATH;
            else if (is_token(b)) part_next = PART_METHOD;
            else phase_next = PH_FAIL;
          end else begin
            if (b == CH_SPACE) phase_next = PH_CODE;
            else if (is_ctl(b)) phase_next = PH_FAIL;
            else part_next = PART_VERSION;
          end
        end
        PH_PATH: begin
          if (b == CH_SPACE) phase_next = PH_VERSION;
          else if (is_ctl(b)) phase_next = PH_FAIL;
          else if (b == CH_QUERY && !cur_query) in_query_next = 1'b1;
          else part_next = cur_query ? PART_QUERY : PART_PATH;
        end
        PH_VERSION: begin
          if (b == CH_CR) awaiting_lf_next = 1'b1;
          else if (is_ctl(b)) phase_next = PH_FAIL;
          else part_next = PART_VERSION;
        end
        PH_CODE: begin
          if (b == CH_SPACE) phase_next = PH_REASON;
          else if (is_token(b)) part_next = PART_CODE;
          else phase_next = PH_FAIL;
        end
        PH_REASON: begin
          if (b == CH_CR) awaiting_lf_next = 1'b1;
          else if (is_ctl(b)) phase_next = PH_FAIL;
          else part_next = PART_REASON;
        end
        PH_NAME: begin
          if (b == CH_CR) begin
            if (cur_pos != '0 || cur_mis) phase_next = PH_FAIL;
            else awaiting_lf_next = 1'b1;
          end else if (cur_headers >= HDR_W'(MAX_HEADERS)) begin
            phase_next = PH_FAIL;
          end else if (b == CH_COLON) begin
            phase_next = PH_COLON_SPACE;
          end else if (is_token(b)) begin
            part_next = PART_NAME;
            if (!cur_mis && cur_pos < POS_W'(KEY_LEN) && b == key_char(cur_pos)) begin
              match_pos_next = cur_pos + POS_W'(1);
            end else begin
              mismatch_next = 1'b1;
            end
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_COLON_SPACE: begin
          if (b == CH_SPACE) begin
            phase_next        = PH_VALUE;
            accum_next        = '0;
            digits_ended_next = 1'b0;
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_VALUE: begin
          if (b == CH_CR) begin
            awaiting_lf_next = 1'b1;
          end else if (is_ctl(b)) begin
            phase_next = PH_FAIL;
          end else begin
            part_next = PART_VALUE;
            if (!cur_ended && b >= CH_ZERO && b <= CH_NINE) begin
              accum_next = (accum_sum[35:32] != 4'd0) ? '1 : accum_sum[31:0];
            end else begin
              digits_ended_next = 1'b1;
            end
          end
        end
        PH_CONTENT: begin
          part_next  = PART_CONTENT;
          count_next = cur_count + 32'd1;
          if (count_next >= cur_length) phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_FAIL;
        end
      endcase
    end
  end

  // advance parser state as each beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      awaiting_lf  <= 1'b0;
      in_query     <= 1'b0;
      match_pos    <= '0;
      mismatch     <= 1'b0;
      accum        <= '0;
      digits_ended <= 1'b0;
      length       <= '0;
      count        <= '0;
      headers      <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      awaiting_lf  <= awaiting_lf_next;
      in_query     <= in_query_next;
      match_pos    <= match_pos_next;
      mismatch     <= mismatch_next;
      accum        <= accum_next;
      digits_ended <= digits_ended_next;
      length       <= length_next;
      count        <= count_next;
      headers      <= headers_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_byte       <= b;
      out_data.part           <= part_next;
      out_data.header_index   <= headers_next[5:0];
      out_data.parse_status   <= (phase_next == PH_DONE) ? STAT_COMPLETE :
                                 (phase_next == PH_FAIL) ? STAT_FAILED : STAT_PENDING;
      out_data.content_length <= length_next;
    end
  end

endmodule

/* verif/http_message_header_parser_check.sv */
// ----------------------------------------------------------------------------
// HTTP message header parser checker
// Watches the input, result and mode channels. Each input beat is run
// through a cycle-free model of the parser, and each result beat is
// compared field by field with the oldest tagged beat still outstanding.
// ----------------------------------------------------------------------------
module http_message_header_parser_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  hmhp_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  hmhp_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  output int                  fail_count,
  output int                  outstanding
);
  import hmhp_pkg::*;

  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "Content-Length";

  logic        mode;
  phase_t      ph;
  logic        lf_wait;
  logic        q_open;
  logic [4:0]  key_pos;
  logic        key_miss;
  logic [31:0] acc;
  logic        digits_done;
  logic [31:0] clen;
  logic [31:0] body_cnt;
  logic [6:0]  hdr_cnt;

  out_beat_t tagged_beats[$];
  out_beat_t next_beat;
  out_beat_t want;
  int        mismatches = 0;
  int        beats_seen = 0;

  function automatic logic ctl_byte(input logic [7:0] b);
    return (b <= CH_CTL) || (b == CH_DEL);
  endfunction

  function automatic logic sep_byte(input logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", 8'h5c, 8'h22,
      "/", "[", "]", "?", "=", "{", "}", " ", 8'h09:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

  function automatic logic token_byte(input logic [7:0] b);
    return (b < 8'h80) && !ctl_byte(b) && !sep_byte(b);
  endfunction

  task automatic clear_parser();
    ph          = PH_START;
    lf_wait     = 1'b0;
    q_open      = 1'b0;
    key_pos     = '0;
    key_miss    = 1'b0;
    acc         = '0;
    digits_done = 1'b0;
    clen        = '0;
    body_cnt    = '0;
    hdr_cnt     = '0;
  endtask

  task automatic tag_byte(input in_beat_t ib, output out_beat_t ob);
    logic [7:0]  b;
    logic [3:0]  tag;
    logic [35:0] prod;
    b   = ib.in_byte;
    tag = PART_DELIM;
    if (ib.message_start) clear_parser();

    if (ph == PH_DONE || ph == PH_FAIL) begin
      // hold the status
    end else if (lf_wait) begin
      lf_wait = 1'b0;
      if (b != CH_LF) ph = PH_FAIL;
      else if (ph == PH_VERSION || ph == PH_REASON || ph == PH_VALUE) begin
        if (ph == PH_VALUE) begin
          if (!key_miss && key_pos == KEY_LEN) clen = acc;
          if (hdr_cnt < MAX_HEADERS) hdr_cnt++;
        end
        key_pos  = '0;
        key_miss = 1'b0;
        ph       = PH_NAME;
      end else if (ph == PH_NAME) begin
        ph = (clen != 0) ? PH_CONTENT : PH_DONE;
      end else begin
        ph = PH_FAIL;
      end
    end else begin
      case (ph)
        PH_START: begin
          if (mode == MODE_REQUEST) begin
            if (b == CH_SPACE) ph = PH_PATH;
            else if (token_byte(b)) tag = PART_METHOD;
            else ph = PH_FAIL;
          end else begin
            if (b == CH_SPACE) ph = PH_CODE;
            else if (ctl_byte(b)) ph = PH_FAIL;
            else tag = PART_VERSION;
          end
        end
        PH_PATH: begin
          if (b == CH_SPACE) ph = PH_VERSION;
          else if (ctl_byte(b)) ph = PH_FAIL;
          else if (b == CH_QUERY && !q_open) q_open = 1'b1;
          else tag = q_open ? PART_QUERY : PART_PATH;
        end
        PH_VERSION: begin
          if (b == CH_CR) lf_wait = 1'b1;
          else if (ctl_byte(b)) ph = PH_FAIL;
          else tag = PART_VERSION;
        end
        PH_CODE: begin
          if (b == CH_SPACE) ph = PH_REASON;
          else if (token_byte(b)) tag = PART_CODE;
          else ph = PH_FAIL;
        end
        PH_REASON: begin
          if (b == CH_CR) lf_wait = 1'b1;
          else if (ctl_byte(b)) ph = PH_FAIL;
          else tag = PART_REASON;
        end
        PH_NAME: begin
          if (b == CH_CR) begin
            if (key_pos != 0 || key_miss) ph = PH_FAIL;
            else lf_wait = 1'b1;
          end else if (hdr_cnt >= MAX_HEADERS) begin
            ph = PH_FAIL;
          end else if (b == CH_COLON) begin
            ph = PH_COLON_SPACE;
          end else if (token_byte(b)) begin
            tag = PART_NAME;
            if (!key_miss && key_pos < KEY_LEN &&
                b == KEY_TEXT[8*(KEY_LEN-1-int'(key_pos)) +: 8])
              key_pos++;
            else
              key_miss = 1'b1;
          end else begin
            ph = PH_FAIL;
          end
        end
        PH_COLON_SPACE: begin
          if (b == CH_SPACE) begin
            ph          = PH_VALUE;
            acc         = '0;
            digits_done = 1'b0;
          end else begin
            ph = PH_FAIL;
          end
        end
        PH_VALUE: begin
          if (b == CH_CR) lf_wait = 1'b1;
          else if (ctl_byte(b)) ph = PH_FAIL;
          else begin
            tag = PART_VALUE;
            if (!digits_done && b >= CH_ZERO && b <= CH_NINE) begin
              prod = 36'(acc) * 36'd10 + 36'(b - CH_ZERO);
              acc  = (prod > 36'hffff_ffff) ? 32'hffff_ffff : prod[31:0];
            end else begin
              digits_done = 1'b1;
            end
          end
        end
        PH_CONTENT: begin
          tag = PART_CONTENT;
          body_cnt++;
          if (body_cnt >= clen) ph = PH_DONE;
        end
        default: ph = PH_FAIL;
      endcase
    end

    ob.out_byte       = b;
    ob.part           = tag;
    ob.header_index   = hdr_cnt[5:0];
    ob.parse_status   = (ph == PH_DONE) ? STAT_COMPLETE :
                        (ph == PH_FAIL) ? STAT_FAILED : STAT_PENDING;
    ob.content_length = clen;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch in %s at result beat %0d: got %0h, wanted %0h",
             what, beats_seen, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_REQUEST;
      clear_parser();
      tagged_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) mode = cfg_data;
      if (in_valid && !in_stall) begin
        tag_byte(in_data, next_beat);
        tagged_beats.push_back(next_beat);
      end
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (tagged_beats.size() == 0) begin
          report_mismatch("unexpected beat", 32'(out_data.out_byte), '0);
        end else begin
          want = tagged_beats.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
          if (out_data.part !== want.part)
            report_mismatch("part", 32'(out_data.part), 32'(want.part));
          if (out_data.header_index !== want.header_index)
            report_mismatch("header_index", 32'(out_data.header_index),
                            32'(want.header_index));
          if (out_data.parse_status !== want.parse_status)
            report_mismatch("parse_status", 32'(out_data.parse_status),
                            32'(want.parse_status));
          if (out_data.content_length !== want.content_length)
            report_mismatch("content_length", out_data.content_length,
                            want.content_length);
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= tagged_beats.size();
  end

endmodule

/* verif/http_message_header_parser_test.sv */
// ----------------------------------------------------------------------------
// HTTP message header parser testbench
// Feeds requests and responses, well formed, broken and pure noise, under
// three throttling patterns and both parse modes. A checker beside the
// parser predicts every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module http_message_header_parser_test;
  import hmhp_pkg::*;

  localparam int LIMIT = 400000;

  typedef logic [7:0] byte_list_t[$];

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  int    fail_count;
  int    outstanding;
  int    send_idle = 7;
  int    recv_idle = 58;
  int    cycles = 0;
  int    bytes_sent = 0;
  int    messages = 0;
  int    mode_writes = 0;
  logic  cur_mode = MODE_REQUEST;
  string token_set = "abcxyzAZ09-!#$%&'*+.^_`|~";

  http_message_header_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  http_message_header_parser_check check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  function automatic logic [7:0] pick_token();
    return token_set[$urandom_range(token_set.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_visible(input bit with_space);
    logic [7:0] c;
    do begin
      if ($urandom_range(3) == 0) c = 8'($urandom_range(128, 255));
      else c = 8'($urandom_range(32, 126));
    end while (!with_space && c == CH_SPACE);
    return c;
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(5))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_COLON;
      3: return CH_SPACE;
      4: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_text(ref byte_list_t m, input string s);
    for (int i = 0; i < s.len(); i++) m.push_back(s[i]);
  endfunction

  function automatic void push_crlf(ref byte_list_t m);
    m.push_back(CH_CR);
    m.push_back(CH_LF);
  endfunction

  task automatic build_message(input logic resp, input int n_hdr, output byte_list_t m);
    int    body;
    int    val;
    int    k;
    string v;
    m    = {};
    body = 0;
    if (resp == MODE_REQUEST) begin
      repeat ($urandom_range(4)) m.push_back(pick_token());
      m.push_back(CH_SPACE);
      repeat ($urandom_range(5)) m.push_back(pick_visible(1'b0));
      if ($urandom_range(1)) begin
        m.push_back(CH_QUERY);
        repeat ($urandom_range(5)) m.push_back(pick_visible(1'b0));
      end
      m.push_back(CH_SPACE);
      repeat ($urandom_range(1, 8)) m.push_back(pick_visible(1'b1));
    end else begin
      repeat ($urandom_range(1, 8)) m.push_back(pick_visible(1'b0));
      m.push_back(CH_SPACE);
      repeat ($urandom_range(3)) m.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      m.push_back(CH_SPACE);
      repeat ($urandom_range(8)) m.push_back(pick_visible(1'b1));
    end
    push_crlf(m);

    repeat (n_hdr) begin
      k = (n_hdr > 8) ? 8 : $urandom_range(9);
      if (k <= 2) begin
        push_text(m, "Content-Length");
        case ($urandom_range(7))
          0: begin
            v    = "4294967295";
            body = 3;
          end
          1: begin
            v    = "99999999999";
            body = 3;
          end
          2: begin
            val  = $urandom_range(9);
            v    = $sformatf("%03d", val);
            body = val;
          end
          default: begin
            val  = $urandom_range(12);
            v    = $sformatf("%0d", val);
            body = val;
          end
        endcase
        if ($urandom_range(3) == 0) v = {v, "x7"};
      end else if (k == 3) begin
        case ($urandom_range(2))
          0: push_text(m, "content-length");
          1: push_text(m, "Content-Len");
          default: push_text(m, "Content-Lengths");
        endcase
        v = $sformatf("%0d", $urandom_range(20));
      end else if (k == 8) begin
        v = "";
      end else begin
        repeat ($urandom_range(1, 6)) m.push_back(pick_token());
        v = "";
        repeat ($urandom_range(6)) v = {v, string'(pick_visible(1'b1))};
      end
      m.push_back(CH_COLON);
      m.push_back(CH_SPACE);
      push_text(m, v);
      push_crlf(m);
    end

    if (n_hdr > 8 && $urandom_range(1)) begin
      // one header past the limit
      m.push_back($urandom_range(1) ? CH_COLON : pick_token());
    end else begin
      push_crlf(m);
      repeat (body) m.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(2)) m.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, message_start: st};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_list(input byte_list_t m, input bit noise);
    foreach (m[i]) send_byte(m[i], noise ? ($urandom_range(9) == 0) : (i == 0));
    messages++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  initial begin
    byte_list_t m;
    int         k;
    int         idx;
    int         target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // request with empty-ish parts, repeated query mark and high bytes
    m = {};
    push_text(m, "A /?q?");
    m.push_back(8'h80);
    push_text(m, " H");
    push_crlf(m);
    push_crlf(m);
    m.push_back(8'hff);
    send_list(m, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(CH_DEL, 1'b0);
    // response with empty version and code, mode flipped mid-message
    write_mode(1'b1);
    send_byte(CH_SPACE, 1'b1);
    send_byte(CH_SPACE, 1'b0);
    send_byte("x", 1'b0);
    write_mode(MODE_REQUEST);
    send_byte("z", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte("y", 1'b0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 7;
          recv_idle <= 58;
        end
        1: begin
          send_idle = 58;
          recv_idle <= 7;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        write_mode(1'(seg % 2));
        target = bytes_sent + 30;
        if (p == 0 && seg == 1) begin
          build_message(cur_mode, MAX_HEADERS, m);
          send_list(m, 1'b0);
        end
        while (bytes_sent < target) begin
          k = $urandom_range(19);
          if (k < 2) begin
            m = {};
            repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(255)));
            send_list(m, 1'b1);
          end else begin
            build_message(cur_mode, $urandom_range(3), m);
            if (k < 6) begin
              idx    = $urandom_range(m.size() - 1);
              m[idx] = pick_special();
            end else if (k == 6) begin
              m = m[0:$urandom_range(m.size() - 1)];
            end
            send_list(m, 1'b0);
          end
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("sent %0d bytes in %0d messages with %0d mode writes;", bytes_sent, messages,
             mode_writes);
    $display("requests and responses, broken and noisy, throttled both ways and unthrottled");
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hmhp_pkg.sv
rtl/http_message_header_parser.sv
verif/http_message_header_parser_check.sv
verif/http_message_header_parser_test.sv
